[src/rsm_pkg.sv]
// Shared definitions of the running statistics merge block: widths, codes,
// the control structs between modules and the merge micro-program.
// Depends on nothing; every other file imports it.
package rsm_pkg;

  // Field widths.
  localparam int VALUE_W = 32;
  localparam int FRAC_W  = 16;
  localparam int VAR_W   = VALUE_W + FRAC_W;
  localparam int COUNT_W = 32;
  localparam int DIFF_W  = VALUE_W + 1;

  // Shared multiplier: signed operands that hold any count, limb or mean difference.
  localparam int LIMB_W  = COUNT_W;
  localparam int MOP_W   = COUNT_W + 2;
  localparam int PROD_W  = 2 * MOP_W;
  // Accumulator and dividend: the widest numerator is below 2^(3*COUNT_W).
  localparam int ACC_W   = 3 * COUNT_W + 2;
  // Quotient register: the widest quotient (correction term) is below 2^(2*COUNT_W).
  localparam int QUO_W   = 2 * COUNT_W;
  localparam int VSUM_W  = QUO_W - FRAC_W + 1;

  // Quotient bits per division kind, and divider iterations at two bits a cycle.
  localparam int KQ_MEAN = VALUE_W;
  localparam int KQ_LIN  = VAR_W;
  localparam int KQ_CORR = QUO_W;
  localparam int DIV_BITS_PER_CYCLE = 2;
  localparam int DIV_CNT_W = $clog2(QUO_W / DIV_BITS_PER_CYCLE + 1);
  localparam int DIV_STEPS_MEAN = KQ_MEAN / DIV_BITS_PER_CYCLE;
  localparam int DIV_STEPS_LIN  = KQ_LIN / DIV_BITS_PER_CYCLE;
  localparam int DIV_STEPS_CORR = KQ_CORR / DIV_BITS_PER_CYCLE;

  // Top-level control states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN,
    ST_DONE
  } state_t;

  // How an accepted item changes the stored summary.
  typedef enum logic [1:0] {
    UPD_COPY,
    UPD_KEEP,
    UPD_OVF,
    UPD_MERGE
  } upd_t;

  // Micro-operation codes and their operand selects.
  typedef enum logic [1:0] {
    UOP_MAC,
    UOP_XLD,
    UOP_DIV,
    UOP_FIN
  } uop_code_t;

  typedef enum logic [3:0] {
    A_M1,
    A_M2,
    A_V1LO,
    A_V1HI,
    A_V2LO,
    A_V2HI,
    A_D,
    A_XLO,
    A_XHI
  } asel_t;

  typedef enum logic [1:0] {
    B_N1,
    B_N2,
    B_D
  } bsel_t;

  typedef enum logic [1:0] {
    DK_MEAN,
    DK_LIN,
    DK_CORR
  } dkind_t;

  typedef enum logic [1:0] {
    DST_MEAN,
    DST_LIN,
    DST_X
  } dst_t;

  typedef struct packed {
    uop_code_t op;
    asel_t     asel;
    bsel_t     bsel;
    logic      clr;
    logic      hi;
    dkind_t    dk;
    dst_t      dst;
  } uop_t;

  // Merge program: weighted mean, weighted variance, then the correction
  // term d*d*n1/N*n2/N, and finally the saturating sum.
  localparam int PROG_LEN = 17;
  localparam int STEP_W   = $clog2(PROG_LEN);
  localparam uop_t PROG [PROG_LEN] = '{
    '{UOP_MAC, A_M1,   B_N1, 1'b1, 1'b0, DK_MEAN, DST_MEAN},
    '{UOP_MAC, A_M2,   B_N2, 1'b0, 1'b0, DK_MEAN, DST_MEAN},
    '{UOP_DIV, A_M1,   B_N1, 1'b0, 1'b0, DK_MEAN, DST_MEAN},
    '{UOP_MAC, A_V1LO, B_N1, 1'b1, 1'b0, DK_LIN,  DST_LIN},
    '{UOP_MAC, A_V1HI, B_N1, 1'b0, 1'b1, DK_LIN,  DST_LIN},
    '{UOP_MAC, A_V2LO, B_N2, 1'b0, 1'b0, DK_LIN,  DST_LIN},
    '{UOP_MAC, A_V2HI, B_N2, 1'b0, 1'b1, DK_LIN,  DST_LIN},
    '{UOP_DIV, A_M1,   B_N1, 1'b0, 1'b0, DK_LIN,  DST_LIN},
    '{UOP_MAC, A_D,    B_D,  1'b1, 1'b0, DK_CORR, DST_X},
    '{UOP_XLD, A_D,    B_D,  1'b0, 1'b0, DK_CORR, DST_X},
    '{UOP_MAC, A_XLO,  B_N1, 1'b1, 1'b0, DK_CORR, DST_X},
    '{UOP_MAC, A_XHI,  B_N1, 1'b0, 1'b1, DK_CORR, DST_X},
    '{UOP_DIV, A_M1,   B_N1, 1'b0, 1'b0, DK_CORR, DST_X},
    '{UOP_MAC, A_XLO,  B_N2, 1'b1, 1'b0, DK_CORR, DST_X},
    '{UOP_MAC, A_XHI,  B_N2, 1'b0, 1'b1, DK_CORR, DST_X},
    '{UOP_DIV, A_M1,   B_N1, 1'b0, 1'b0, DK_CORR, DST_X},
    '{UOP_FIN, A_M1,   B_N1, 1'b0, 1'b0, DK_CORR, DST_X}
  };

  // Operands of one merge, held by the top level while the sequencer runs.
  typedef struct packed {
    logic        [COUNT_W-1:0] n1;
    logic        [COUNT_W-1:0] n2;
    logic        [COUNT_W-1:0] total;
    logic signed [VALUE_W-1:0] m1;
    logic signed [VALUE_W-1:0] m2;
    logic        [VAR_W-1:0]   v1;
    logic        [VAR_W-1:0]   v2;
  } merge_ops_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] mean;
    logic        [VAR_W-1:0]   variance;
  } merge_res_t;

  typedef struct packed {
    logic                    issue;
    logic                    clr;
    logic                    hi;
    logic signed [MOP_W-1:0] a;
    logic signed [MOP_W-1:0] b;
  } mac_cmd_t;

  typedef struct packed {
    logic   start;
    logic   abs_en;
    dkind_t dk;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic neg;
  } div_stat_t;

endpackage

[src/rsm_ifs.sv]
// Valid/ready channel interfaces for the input items and the result items.
// Depends on rsm_pkg for the field widths.
interface rsm_in_if;
  import rsm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic signed [VALUE_W-1:0] value;
  logic        [COUNT_W-1:0] batch_count;
  logic        [VAR_W-1:0]   batch_variance;
  logic signed [VALUE_W-1:0] batch_min;
  logic signed [VALUE_W-1:0] batch_max;

  modport source (
    output valid, kind, value, batch_count, batch_variance, batch_min, batch_max,
    input  ready
  );
  modport sink (
    input  valid, kind, value, batch_count, batch_variance, batch_min, batch_max,
    output ready
  );
endinterface

interface rsm_out_if;
  import rsm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic        [COUNT_W-1:0] total_count;
  logic signed [VALUE_W-1:0] running_mean;
  logic        [VAR_W-1:0]   running_variance;
  logic signed [VALUE_W-1:0] running_min;
  logic signed [VALUE_W-1:0] running_max;
  logic                      count_overflow;

  modport source (
    output valid, total_count, running_mean, running_variance, running_min,
           running_max, count_overflow,
    input  ready
  );
  modport sink (
    input  valid, total_count, running_mean, running_variance, running_min,
           running_max, count_overflow,
    output ready
  );
endinterface

[src/rsm_mac.sv]
// Shared signed multiply-accumulate unit: one registered product a cycle,
// added into the wide accumulator at limb offset zero or one.
// Depends on rsm_pkg.
module rsm_mac (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rsm_pkg::mac_cmd_t         cmd,
  output logic                      busy,
  output logic [rsm_pkg::ACC_W-1:0] acc
);
  import rsm_pkg::*;

  logic signed [PROD_W-1:0] p_r, p_nxt;
  logic                     p_valid_r;
  logic                     p_clr_r;
  logic                     p_hi_r;
  logic        [ACC_W-1:0]  acc_r, acc_nxt;
  logic        [ACC_W-1:0]  p_ext;

  // Product stage.
  assign p_nxt = cmd.a * cmd.b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      p_r     <= p_nxt;
      p_clr_r <= cmd.clr;
      p_hi_r  <= cmd.hi;
    end
  end

  // Accumulate stage: sign-extend the product and place it on its limb.
  always_comb begin
    p_ext = {{(ACC_W - PROD_W){p_r[PROD_W-1]}}, p_r};
    if (p_hi_r) begin
      p_ext = p_ext << LIMB_W;
    end
    acc_nxt = (p_clr_r ? '0 : acc_r) + p_ext;
  end

  always_ff @(posedge clk) begin
    if (p_valid_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign busy = p_valid_r;
  assign acc  = acc_r;

endmodule

[src/rsm_div.sv]
// Restoring divider, two quotient bits a cycle, for a wide dividend and a
// count-wide divisor whose quotient is known to fit a given number of bits.
// Depends on rsm_pkg.
module rsm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rsm_pkg::div_cmd_t           cmd,
  input  logic [rsm_pkg::ACC_W-1:0]   dividend,
  input  logic [rsm_pkg::COUNT_W-1:0] divisor,
  output rsm_pkg::div_stat_t          stat,
  output logic [rsm_pkg::QUO_W-1:0]   quotient
);
  import rsm_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic                 neg_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [COUNT_W-1:0]   rem_r, rem_nxt;
  logic [ACC_W-1:0]     work_r, work_nxt;
  logic [ACC_W-1:0]     mag;
  logic                 mag_neg;
  logic [COUNT_W-1:0]   rem_load;
  logic [ACC_W-1:0]     work_load;
  logic [DIV_CNT_W-1:0] cnt_load;

  // Magnitude of the dividend, and its alignment for the chosen quotient size.
  // The high part goes straight into the remainder; the rest is shifted in.
  always_comb begin
    mag_neg = cmd.abs_en && dividend[ACC_W-1];
    mag     = mag_neg ? (ACC_W'(0) - dividend) : dividend;
    unique case (cmd.dk)
      DK_MEAN: begin
        rem_load  = COUNT_W'(mag >> KQ_MEAN);
        work_load = mag << (ACC_W - KQ_MEAN);
        cnt_load  = DIV_CNT_W'(DIV_STEPS_MEAN);
      end
      DK_LIN: begin
        rem_load  = COUNT_W'(mag >> KQ_LIN);
        work_load = mag << (ACC_W - KQ_LIN);
        cnt_load  = DIV_CNT_W'(DIV_STEPS_LIN);
      end
      DK_CORR: begin
        rem_load  = COUNT_W'(mag >> KQ_CORR);
        work_load = mag << (ACC_W - KQ_CORR);
        cnt_load  = DIV_CNT_W'(DIV_STEPS_CORR);
      end
      default: begin
        rem_load  = '0;
        work_load = '0;
        cnt_load  = '0;
      end
    endcase
  end

  // Two trial subtractions; quotient bits enter the bottom of the work word.
  always_comb begin
    rem_nxt  = rem_r;
    work_nxt = work_r;
    for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
      logic [COUNT_W:0] trial;
      logic             fits;
      trial    = {rem_nxt, work_nxt[ACC_W-1]};
      fits     = trial >= {1'b0, divisor};
      rem_nxt  = fits ? COUNT_W'(trial - {1'b0, divisor}) : trial[COUNT_W-1:0];
      work_nxt = {work_nxt[ACC_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= cnt_load;
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem_r  <= rem_load;
      work_r <= work_load;
      neg_r  <= mag_neg;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      work_r <= work_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign stat.neg  = neg_r;
  assign quotient  = work_r[QUO_W-1:0];

endmodule

[src/rsm_seq.sv]
// Merge sequencer: steps through the micro-program, feeding the shared
// multiply-accumulate unit and the shared divider, and keeps the partial results.
// Depends on rsm_pkg, rsm_mac and rsm_div.
module rsm_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  rsm_pkg::merge_ops_t ops,
  output logic                done,
  output rsm_pkg::merge_res_t res
);
  import rsm_pkg::*;

  logic                      run_r;
  logic [STEP_W-1:0]         step_r;
  logic                      issued_r;
  logic                      done_r;
  logic signed [DIFF_W-1:0]  d_r;
  logic [QUO_W-1:0]          x_r;
  logic [VAR_W-1:0]          lin_r;
  logic signed [VALUE_W-1:0] mean_r;
  logic [VAR_W-1:0]          var_r, var_nxt;
  logic [VSUM_W-1:0]         var_sum;

  uop_t                      uop;
  mac_cmd_t                  mac_cmd;
  logic                      mac_issue;
  logic                      mac_busy;
  logic [ACC_W-1:0]          mac_acc;
  div_cmd_t                  div_cmd;
  div_stat_t                 div_stat;
  logic [QUO_W-1:0]          div_q;
  logic [VALUE_W-1:0]        q_mean;

  logic                      advance;
  logic                      load_x;
  logic                      capture;
  logic                      fin;

  rsm_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mac_cmd),
    .busy  (mac_busy),
    .acc   (mac_acc)
  );

  rsm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (div_cmd),
    .dividend (mac_acc),
    .divisor  (ops.total),
    .stat     (div_stat),
    .quotient (div_q)
  );

  assign uop = PROG[step_r];

  // Multiplier operand selection.
  always_comb begin
    mac_cmd.issue = mac_issue;
    mac_cmd.clr   = uop.clr;
    mac_cmd.hi    = uop.hi;
    unique case (uop.asel)
      A_M1:    mac_cmd.a = {{(MOP_W - VALUE_W){ops.m1[VALUE_W-1]}}, ops.m1};
      A_M2:    mac_cmd.a = {{(MOP_W - VALUE_W){ops.m2[VALUE_W-1]}}, ops.m2};
      A_V1LO:  mac_cmd.a = {{(MOP_W - LIMB_W){1'b0}}, ops.v1[LIMB_W-1:0]};
      A_V1HI:  mac_cmd.a = {{(MOP_W - VAR_W + LIMB_W){1'b0}}, ops.v1[VAR_W-1:LIMB_W]};
      A_V2LO:  mac_cmd.a = {{(MOP_W - LIMB_W){1'b0}}, ops.v2[LIMB_W-1:0]};
      A_V2HI:  mac_cmd.a = {{(MOP_W - VAR_W + LIMB_W){1'b0}}, ops.v2[VAR_W-1:LIMB_W]};
      A_D:     mac_cmd.a = {{(MOP_W - DIFF_W){d_r[DIFF_W-1]}}, d_r};
      A_XLO:   mac_cmd.a = {{(MOP_W - LIMB_W){1'b0}}, x_r[LIMB_W-1:0]};
      A_XHI:   mac_cmd.a = {{(MOP_W - QUO_W + LIMB_W){1'b0}}, x_r[QUO_W-1:LIMB_W]};
      default: mac_cmd.a = '0;
    endcase
    unique case (uop.bsel)
      B_N1:    mac_cmd.b = {{(MOP_W - COUNT_W){1'b0}}, ops.n1};
      B_N2:    mac_cmd.b = {{(MOP_W - COUNT_W){1'b0}}, ops.n2};
      B_D:     mac_cmd.b = {{(MOP_W - DIFF_W){d_r[DIFF_W-1]}}, d_r};
      default: mac_cmd.b = '0;
    endcase
  end

  // Step control. Anything that reads the accumulator waits for the
  // product still in flight to land.
  always_comb begin
    mac_issue      = 1'b0;
    div_cmd.start  = 1'b0;
    div_cmd.abs_en = (uop.dst == DST_MEAN);
    div_cmd.dk     = uop.dk;
    advance        = 1'b0;
    load_x         = 1'b0;
    capture        = 1'b0;
    fin            = 1'b0;
    if (run_r) begin
      unique case (uop.op)
        UOP_MAC: begin
          mac_issue = 1'b1;
          advance   = 1'b1;
        end
        UOP_XLD: begin
          if (!mac_busy) begin
            load_x  = 1'b1;
            advance = 1'b1;
          end
        end
        UOP_DIV: begin
          if (!issued_r && !mac_busy) begin
            div_cmd.start = 1'b1;
          end else if (issued_r && div_stat.done) begin
            capture = 1'b1;
            advance = 1'b1;
          end
        end
        UOP_FIN: begin
          fin = 1'b1;
        end
        default: begin
          fin = 1'b0;
        end
      endcase
    end
  end

  // Mean sign restored after the magnitude division; variance saturates.
  always_comb begin
    q_mean  = div_q[VALUE_W-1:0];
    var_sum = {{(VSUM_W - VAR_W){1'b0}}, lin_r}
            + {1'b0, x_r[QUO_W-1:FRAC_W]};
    if (var_sum[VSUM_W-1:VAR_W] != '0) begin
      var_nxt = '1;
    end else begin
      var_nxt = var_sum[VAR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= 1'b0;
      step_r   <= '0;
      issued_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r    <= 1'b1;
        step_r   <= '0;
        issued_r <= 1'b0;
      end else if (fin) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end else begin
        if (div_cmd.start) begin
          issued_r <= 1'b1;
        end else if (capture) begin
          issued_r <= 1'b0;
        end
        if (advance) begin
          step_r <= step_r + STEP_W'(1);
        end
      end
    end
  end

  // Partial results.
  always_ff @(posedge clk) begin
    if (start) begin
      d_r <= {ops.m2[VALUE_W-1], ops.m2} - {ops.m1[VALUE_W-1], ops.m1};
    end
    if (load_x) begin
      x_r <= mac_acc[QUO_W-1:0];
    end
    if (capture) begin
      unique case (uop.dst)
        DST_MEAN: mean_r <= div_stat.neg ? (VALUE_W'(0) - q_mean) : q_mean;
        DST_LIN:  lin_r  <= div_q[VAR_W-1:0];
        DST_X:    x_r    <= div_q;
        default:  x_r    <= div_q;
      endcase
    end
    if (fin) begin
      var_r <= var_nxt;
    end
  end

  assign done         = done_r;
  assign res.mean     = mean_r;
  assign res.variance = var_r;

endmodule

[src/running_stats_merge.sv]
// Running statistics merge: top level with the control state machine, the
// stored summary and the result register.
// Depends on rsm_pkg, rsm_ifs and rsm_seq.

// The block keeps the count, mean (Q16.16), population variance (unsigned
// Q32.16, saturating), minimum and maximum of everything fed to it, and
// returns the updated summary for each input item. An item is either one
// sample or a batch summary; merging one uses the parallel combination rule
// with truncating divisions. An item that merges into a non-empty store runs
// four divisions on the shared divider (two quotient bits a cycle) and the
// shared multiplier behind it before the next input transfer; copying into an
// empty store, ignoring an empty batch or refusing a merge whose count would
// overflow bypasses the merge sequencer.
// Input is accepted only between items; a finished result sits in the output
// register, so the next item may be taken before the result has been
// transferred.
module running_stats_merge (
  input  logic     clk,
  input  logic     rst_n,
  rsm_in_if.sink   in_ch,
  rsm_out_if.source out_ch
);
  import rsm_pkg::*;

  state_t                    state_r, state_nxt;
  upd_t                      upd_r, upd_dec;

  // Latched item, already turned into batch form.
  logic        [COUNT_W-1:0] n2_r;
  logic signed [VALUE_W-1:0] m2_r;
  logic        [VAR_W-1:0]   v2_r;
  logic signed [VALUE_W-1:0] lo2_r;
  logic signed [VALUE_W-1:0] hi2_r;

  // Stored summary.
  logic        [COUNT_W-1:0] acc_count_r, acc_count_nxt;
  logic signed [VALUE_W-1:0] acc_mean_r, acc_mean_nxt;
  logic        [VAR_W-1:0]   acc_var_r, acc_var_nxt;
  logic signed [VALUE_W-1:0] acc_min_r, acc_min_nxt;
  logic signed [VALUE_W-1:0] acc_max_r, acc_max_nxt;

  // Result register.
  logic                      out_valid_r;
  logic        [COUNT_W-1:0] out_count_r;
  logic signed [VALUE_W-1:0] out_mean_r;
  logic        [VAR_W-1:0]   out_var_r;
  logic signed [VALUE_W-1:0] out_min_r;
  logic signed [VALUE_W-1:0] out_max_r;
  logic                      out_ovf_r;

  logic        [COUNT_W:0]   total_w;
  logic                      in_ready;
  logic                      seq_start;
  logic                      commit;
  logic                      seq_done;
  merge_ops_t                ops;
  merge_res_t                res;

  rsm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (seq_start),
    .ops   (ops),
    .done  (seq_done),
    .res   (res)
  );

  assign total_w   = {1'b0, acc_count_r} + {1'b0, n2_r};
  assign ops.n1    = acc_count_r;
  assign ops.n2    = n2_r;
  assign ops.total = total_w[COUNT_W-1:0];
  assign ops.m1    = acc_mean_r;
  assign ops.m2    = m2_r;
  assign ops.v1    = acc_var_r;
  assign ops.v2    = v2_r;

  // Classify the item against the stored summary.
  always_comb begin
    if (acc_count_r == '0) begin
      upd_dec = UPD_COPY;
    end else if (n2_r == '0) begin
      upd_dec = UPD_KEEP;
    end else if (total_w[COUNT_W]) begin
      upd_dec = UPD_OVF;
    end else begin
      upd_dec = UPD_MERGE;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = (upd_dec == UPD_MERGE) ? ST_RUN : ST_DONE;
      end
      ST_RUN: begin
        if (seq_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State machine outputs.
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    seq_start = (state_r == ST_CHECK) && (upd_dec == UPD_MERGE);
    commit    = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  end

  // Updated summary, applied when the result is committed.
  always_comb begin
    acc_count_nxt = acc_count_r;
    acc_mean_nxt  = acc_mean_r;
    acc_var_nxt   = acc_var_r;
    acc_min_nxt   = acc_min_r;
    acc_max_nxt   = acc_max_r;
    if (upd_r == UPD_COPY) begin
      acc_count_nxt = n2_r;
      acc_mean_nxt  = m2_r;
      acc_var_nxt   = v2_r;
      acc_min_nxt   = lo2_r;
      acc_max_nxt   = hi2_r;
    end else if (upd_r == UPD_MERGE) begin
      acc_count_nxt = total_w[COUNT_W-1:0];
      acc_mean_nxt  = res.mean;
      acc_var_nxt   = res.variance;
      acc_min_nxt   = (lo2_r < acc_min_r) ? lo2_r : acc_min_r;
      acc_max_nxt   = (hi2_r > acc_max_r) ? hi2_r : acc_max_r;
    end
  end

  // Control registers and stored summary.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      upd_r       <= UPD_KEEP;
      out_valid_r <= 1'b0;
      acc_count_r <= '0;
      acc_mean_r  <= '0;
      acc_var_r   <= '0;
      acc_min_r   <= '0;
      acc_max_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CHECK) begin
        upd_r <= upd_dec;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
        acc_count_r <= acc_count_nxt;
        acc_mean_r  <= acc_mean_nxt;
        acc_var_r   <= acc_var_nxt;
        acc_min_r   <= acc_min_nxt;
        acc_max_r   <= acc_max_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Input transfer: a sample becomes a batch of one with zero variance.
  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      m2_r <= in_ch.value;
      if (in_ch.kind) begin
        n2_r  <= in_ch.batch_count;
        v2_r  <= in_ch.batch_variance;
        lo2_r <= in_ch.batch_min;
        hi2_r <= in_ch.batch_max;
      end else begin
        n2_r  <= COUNT_W'(1);
        v2_r  <= '0;
        lo2_r <= in_ch.value;
        hi2_r <= in_ch.value;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (commit) begin
      out_count_r <= acc_count_nxt;
      out_mean_r  <= acc_mean_nxt;
      out_var_r   <= acc_var_nxt;
      out_min_r   <= acc_min_nxt;
      out_max_r   <= acc_max_nxt;
      out_ovf_r   <= (upd_r == UPD_OVF);
    end
  end

  assign in_ch.ready             = in_ready;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.total_count      = out_count_r;
  assign out_ch.running_mean     = out_mean_r;
  assign out_ch.running_variance = out_var_r;
  assign out_ch.running_min      = out_min_r;
  assign out_ch.running_max      = out_max_r;
  assign out_ch.count_overflow   = out_ovf_r;

endmodule

[verif/tb_running_stats_merge.sv]
`timescale 1ns / 100ps
// Testbench for running_stats_merge: sample and batch items go in over the input
// channel and every result is checked against a bit-exact predictor of the store.
// Depends on rsm_pkg, the channel interfaces in rsm_ifs and the block's top level.
module tb_running_stats_merge;
  import rsm_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 4;
  localparam int MERGE_TARGET = 380;
  localparam int HOLD_CYCLES  = 1500;
  localparam int IDLE_LIMIT   = 12000;
  localparam int DRAIN_CYCLES = 300;
  localparam int PRINT_LIMIT  = 30;
  localparam int WIDE_W       = 128;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_BATCH  = 1'b1;

  localparam logic        [COUNT_W-1:0] COUNT_FULL   = '1;
  localparam logic        [VAR_W-1:0]   VAR_FULL     = '1;
  localparam logic signed [VALUE_W-1:0] VALUE_TOP    = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VALUE_BOTTOM = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef logic [WIDE_W-1:0] wide_t;

  // Receiver stall patterns.
  typedef enum int unsigned {
    RX_OPEN,
    RX_HALF,
    RX_SPARSE,
    RX_RHYTHM
  } rx_mode_t;

  typedef struct packed {
    logic                      kind;
    logic signed [VALUE_W-1:0] value;
    logic        [COUNT_W-1:0] batch_count;
    logic        [VAR_W-1:0]   batch_variance;
    logic signed [VALUE_W-1:0] batch_min;
    logic signed [VALUE_W-1:0] batch_max;
  } stat_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] total_count;
    logic [VALUE_W-1:0] running_mean;
    logic [VAR_W-1:0]   running_variance;
    logic [VALUE_W-1:0] running_min;
    logic [VALUE_W-1:0] running_max;
    logic               count_overflow;
  } stat_result_t;

  // Keeps its own copy of the stored summary and the queue of summaries the
  // block owes us, oldest first.
  class stats_scoreboard;
    logic        [COUNT_W-1:0] n_acc;
    logic signed [VALUE_W-1:0] mean_acc;
    logic        [VAR_W-1:0]   var_acc;
    logic signed [VALUE_W-1:0] min_acc;
    logic signed [VALUE_W-1:0] max_acc;
    stat_result_t              summary_q[$];
    int unsigned               fails;
    int unsigned               checked;

    function new();
      n_acc    = '0;
      mean_acc = '0;
      var_acc  = '0;
      min_acc  = '0;
      max_acc  = '0;
      fails    = 0;
      checked  = 0;
    endfunction

    function int unsigned pending();
      return summary_q.size();
    endfunction

    // Combines one summary with the store and says what happened to it.
    function upd_t fold(input logic [COUNT_W-1:0] n2, logic signed [VALUE_W-1:0] m2,
                        logic [VAR_W-1:0] v2, logic signed [VALUE_W-1:0] lo2,
                        logic signed [VALUE_W-1:0] hi2);
      logic        [COUNT_W:0] total;
      logic signed [VALUE_W:0] diff;
      logic        [VALUE_W:0] diff_mag;
      logic        [VALUE_W-1:0] mag1;
      logic        [VALUE_W-1:0] mag2;
      logic        neg1;
      logic        neg2;
      logic        neg_sum;
      wide_t       t1;
      wide_t       t2;
      wide_t       msum;
      wide_t       quo;
      wide_t       lin;
      wide_t       corr;
      wide_t       vsum;
      // An empty store takes the incoming summary as it is, even an empty one.
      if (n_acc == '0) begin
        n_acc    = n2;
        mean_acc = m2;
        var_acc  = v2;
        min_acc  = lo2;
        max_acc  = hi2;
        return UPD_COPY;
      end
      if (n2 == '0) return UPD_KEEP;
      total = {1'b0, n_acc} + {1'b0, n2};
      if (total[COUNT_W]) return UPD_OVF;

      // Weighted mean, worked in sign and magnitude and truncated toward zero.
      neg1 = mean_acc[VALUE_W-1];
      neg2 = m2[VALUE_W-1];
      mag1 = neg1 ? -mean_acc : mean_acc;
      mag2 = neg2 ? -m2 : m2;
      t1 = wide_t'(mag1) * wide_t'(n_acc);
      t2 = wide_t'(mag2) * wide_t'(n2);
      if (neg1 == neg2) begin
        msum    = t1 + t2;
        neg_sum = neg1;
      end else if (t1 >= t2) begin
        msum    = t1 - t2;
        neg_sum = neg1;
      end else begin
        msum    = t2 - t1;
        neg_sum = neg2;
      end
      quo = msum / wide_t'(total);

      // The mean difference is taken against the mean held before this merge.
      diff     = {m2[VALUE_W-1], m2} - {mean_acc[VALUE_W-1], mean_acc};
      diff_mag = diff[VALUE_W] ? -diff : diff;
      mean_acc = neg_sum ? -quo[VALUE_W-1:0] : quo[VALUE_W-1:0];

      // Weighted variance plus the correction d*d*n1/N*n2/N, then saturation.
      lin  = (wide_t'(var_acc) * wide_t'(n_acc) + wide_t'(v2) * wide_t'(n2)) / wide_t'(total);
      corr = wide_t'(diff_mag) * wide_t'(diff_mag);
      corr = corr * wide_t'(n_acc) / wide_t'(total);
      corr = corr * wide_t'(n2) / wide_t'(total);
      corr = corr >> FRAC_W;
      vsum = lin + corr;
      var_acc = (vsum >= wide_t'(VAR_FULL)) ? VAR_FULL : vsum[VAR_W-1:0];

      n_acc = total[COUNT_W-1:0];
      if (lo2 < min_acc) min_acc = lo2;
      if (hi2 > max_acc) max_acc = hi2;
      return UPD_MERGE;
    endfunction

    // Called for every input transfer: updates the store and queues the summary.
    function upd_t note_input(stat_item_t it);
      upd_t         how;
      stat_result_t want;
      if (it.kind == KIND_SAMPLE)
        how = fold(1, it.value, '0, it.value, it.value);
      else
        how = fold(it.batch_count, it.value, it.batch_variance, it.batch_min, it.batch_max);
      want.total_count      = n_acc;
      want.running_mean     = mean_acc;
      want.running_variance = var_acc;
      want.running_min      = min_acc;
      want.running_max      = max_acc;
      want.count_overflow   = (how == UPD_OVF);
      summary_q.push_back(want);
      return how;
    endfunction

    function void compare_field(string name, logic [63:0] want_v, logic [63:0] got_v);
      if (want_v !== got_v) begin
        if (fails < PRINT_LIMIT)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
        fails++;
      end
    endfunction

    // Called for every result transfer.
    function void check_result(stat_result_t got);
      stat_result_t want;
      if (summary_q.size() == 0) begin
        if (fails < PRINT_LIMIT)
          $display("%0t: result with nothing expected, expected none, actual count %0h mean %0h",
                   $time, got.total_count, got.running_mean);
        fails++;
        return;
      end
      want = summary_q.pop_front();
      checked++;
      compare_field("total_count", want.total_count, got.total_count);
      compare_field("running_mean", want.running_mean, got.running_mean);
      compare_field("running_variance", want.running_variance, got.running_variance);
      compare_field("count_overflow", want.count_overflow, got.count_overflow);
      // Minimum and maximum carry no meaning while the count is zero.
      if (want.total_count != '0) begin
        compare_field("running_min", want.running_min, got.running_min);
        compare_field("running_max", want.running_max, got.running_max);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic hold_arm = 1'b0;

  rsm_in_if  in_ch ();
  rsm_out_if out_ch ();

  running_stats_merge u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  stats_scoreboard sb;
  int unsigned     burst_left;
  int unsigned     n_sent;
  int unsigned     n_merged;
  int unsigned     n_refused;
  int unsigned     n_empty;
  int unsigned     quiet_cycles = 0;

  always #HALF_PERIOD clk = ~clk;

  // Clamps a shifted value to the Q16.16 range.
  function automatic logic signed [VALUE_W-1:0] offset_value(logic signed [VALUE_W-1:0] base,
                                                             longint delta);
    longint sum;
    sum = longint'(base) + delta;
    if (sum > longint'(VALUE_TOP)) return VALUE_TOP;
    if (sum < longint'(VALUE_BOTTOM)) return VALUE_BOTTOM;
    return sum[VALUE_W-1:0];
  endfunction

  function automatic logic signed [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      2: begin
        case ($urandom_range(0, 4))
          0:       return VALUE_TOP;
          1:       return VALUE_BOTTOM;
          2:       return '0;
          3:       return -1;
          default: return 1;
        endcase
      end
      default: return $signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000;
    endcase
  endfunction

  function automatic stat_item_t make_item(logic k, logic signed [VALUE_W-1:0] v,
                                           logic [COUNT_W-1:0] n, logic [VAR_W-1:0] var_in,
                                           logic signed [VALUE_W-1:0] lo,
                                           logic signed [VALUE_W-1:0] hi);
    stat_item_t it;
    it.kind           = k;
    it.value          = v;
    it.batch_count    = n;
    it.batch_variance = var_in;
    it.batch_min      = lo;
    it.batch_max      = hi;
    return it;
  endfunction

  // Mostly samples and well-formed batches; some empty and oversized batches.
  function automatic stat_item_t random_item(logic [COUNT_W-1:0] n_now);
    stat_item_t  it;
    int unsigned sel;
    sel               = $urandom_range(0, 99);
    it.kind           = KIND_BATCH;
    it.value          = random_value();
    it.batch_count    = $urandom;
    it.batch_variance = VAR_W'({$urandom, $urandom});
    it.batch_min      = $urandom;
    it.batch_max      = $urandom;
    if (sel < 45) begin
      // A sample: the batch fields stay random and must be ignored.
      it.kind = KIND_SAMPLE;
    end else if (sel < 88) begin
      case ($urandom_range(0, 9))
        0:       it.batch_count = $urandom_range(1, 32'h0010_0000);
        1, 2:    it.batch_count = $urandom_range(1, 4096);
        default: it.batch_count = $urandom_range(1, 64);
      endcase
      if ($urandom_range(0, 7) != 0)
        it.batch_variance = VAR_W'($urandom >> $urandom_range(0, 16));
      // Now and then the bounds stay random, so they may cross.
      if ($urandom_range(0, 9) != 0) begin
        it.batch_min = offset_value(it.value, -longint'($urandom_range(0, 32'h0100_0000)));
        it.batch_max = offset_value(it.value, longint'($urandom_range(0, 32'h0100_0000)));
      end
    end else if (sel < 94) begin
      it.batch_count = '0;
    end else if (n_now != '0) begin
      // A batch that cannot fit beside what the store already holds.
      it.batch_count = COUNT_FULL - n_now + 1 + $urandom_range(0, n_now - 1);
    end
    return it;
  endfunction

  task automatic pause_sender(int unsigned cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Offers one item within the burst and gap pattern; returns after its transfer.
  task automatic offer(stat_item_t it);
    upd_t how;
    if (burst_left == 0) begin
      pause_sender(($urandom_range(0, 3) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 8));
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid          <= 1'b1;
    in_ch.kind           <= it.kind;
    in_ch.value          <= it.value;
    in_ch.batch_count    <= it.batch_count;
    in_ch.batch_variance <= it.batch_variance;
    in_ch.batch_min      <= it.batch_min;
    in_ch.batch_max      <= it.batch_max;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    how = sb.note_input(it);
    n_sent++;
    case (how)
      UPD_OVF:  n_refused++;
      UPD_KEEP: n_empty++;
      default:  n_merged++;
    endcase
  endtask

  // Receiver: changing stall patterns, plus one long hold-off on request.
  int unsigned hold_left   = 0;
  int unsigned stall_left  = 0;
  int unsigned stall_phase = 0;
  rx_mode_t    stall_mode  = RX_OPEN;
  logic        hold_taken  = 1'b0;

  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_arm && !hold_taken) begin
      out_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES - 1;
      hold_taken   <= 1'b1;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= rx_mode_t'($urandom_range(0, 3));
        stall_left <= $urandom_range(10, 150);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        RX_OPEN:   out_ch.ready <= 1'b1;
        RX_HALF:   out_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:   out_ch.ready <= (stall_phase % 4 != 3);
      endcase
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    stat_result_t got;
    if (out_ch.valid && out_ch.ready) begin
      got.total_count      = out_ch.total_count;
      got.running_mean     = out_ch.running_mean;
      got.running_variance = out_ch.running_variance;
      got.running_min      = out_ch.running_min;
      got.running_max      = out_ch.running_max;
      got.count_overflow   = out_ch.count_overflow;
      sb.check_result(got);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, giving up", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned merged_base;
    sb = new();
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.kind           <= KIND_SAMPLE;
    in_ch.value          <= '0;
    in_ch.batch_count    <= '0;
    in_ch.batch_variance <= '0;
    in_ch.batch_min      <= '0;
    in_ch.batch_max      <= '0;
    burst_left = 0;
    n_sent     = 0;
    n_merged   = 0;
    n_refused  = 0;
    n_empty    = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty batch into the empty store, then a sample copied in.
    offer(make_item(KIND_BATCH, 32'sh0005_8000, '0, 48'h0000_1234_5678, 32'sh0000_7000,
                    -32'sh0000_3000));
    offer(make_item(KIND_SAMPLE, VALUE_BOTTOM, COUNT_FULL, VAR_FULL, VALUE_TOP, VALUE_BOTTOM));
    // Empty batch into a non-empty store is ignored.
    offer(make_item(KIND_BATCH, 32'sh0001_0000, '0, VAR_FULL, VALUE_BOTTOM, VALUE_TOP));
    // Extreme means with all-ones variance, the first with its minimum above
    // its maximum; the third merge drives the variance into saturation.
    offer(make_item(KIND_BATCH, VALUE_TOP, 1, VAR_FULL, VALUE_TOP, VALUE_BOTTOM));
    offer(make_item(KIND_BATCH, VALUE_BOTTOM, 2, VAR_FULL, VALUE_BOTTOM, VALUE_TOP));
    offer(make_item(KIND_BATCH, VALUE_TOP, 4, VAR_FULL, '0, VALUE_TOP));
    // A full-size batch overflows the count and is refused.
    offer(make_item(KIND_BATCH, '0, COUNT_FULL, '0, '0, '0));
    offer(make_item(KIND_SAMPLE, '0, '0, '0, '0, '0));
    offer(make_item(KIND_SAMPLE, -1, '0, '0, '0, '0));
    offer(make_item(KIND_SAMPLE, VALUE_TOP, '0, '0, '0, '0));
    offer(make_item(KIND_SAMPLE, 1, '0, '0, '0, '0));
    // A wide zero-variance batch pulls the variance back down.
    offer(make_item(KIND_BATCH, '0, 4096, '0, -32'sd1000, 32'sd1000));
    offer(make_item(KIND_SAMPLE, 32'sh7FFF_0000, 32'h0000_0005, '0, '0, '0));
    offer(make_item(KIND_BATCH, -32'sh0001_8000, 1, '0, -32'sh0001_8000, -32'sh0001_8000));
    offer(make_item(KIND_BATCH, 32'sh0002_0000, 3, 48'h0000_0001_0000, 32'sh0001_0000,
                    32'sh0003_0000));
    offer(make_item(KIND_SAMPLE, 32'sh8000_0001, '0, '0, '0, '0));
    offer(make_item(KIND_BATCH, VALUE_BOTTOM, 7, VAR_FULL >> 8, VALUE_BOTTOM, VALUE_BOTTOM));

    // Random part; empty and refused items do not count toward the target.
    merged_base = n_merged;
    while (n_merged - merged_base < MERGE_TARGET) begin
      if (n_sent == 120) hold_arm <= 1'b1;
      if (n_sent == 300) begin
        // Let the pipeline run dry before going on.
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      offer(random_item(sb.n_acc));
    end

    // Fill the count to its ceiling, then show that nothing more fits.
    if (sb.n_acc != COUNT_FULL)
      offer(make_item(KIND_BATCH, random_value(), COUNT_FULL - sb.n_acc, '0, VALUE_BOTTOM,
                      VALUE_TOP));
    offer(make_item(KIND_SAMPLE, random_value(), '0, '0, '0, '0));
    offer(make_item(KIND_BATCH, '0, '0, '0, '0, '0));
    offer(make_item(KIND_BATCH, random_value(), 1, '0, '0, '0));

    pause_sender(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items: %0d merged or copied, %0d refused on count overflow, %0d empty.",
             n_sent, n_merged, n_refused, n_empty);
    $display("Checked %0d results across saturation, a full count, a long output stall.",
             sb.checked);
    if (sb.fails == 0 && sb.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
